// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, switched off while rst is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge of clk, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsa_pkg
// Shared widths, constants and control types of the row distance score block.
// ----------------------------------------------------------------------------
package rdsa_pkg;

   localparam int ELEM_W   = 16;   // Q3.12 element
   localparam int PROD_W   = 32;   // one element product, Q.24
   localparam int NORM_W   = 43;   // squared norm sum, unsigned Q.24
   localparam int DOT_W    = 44;   // dot product sum, signed Q.24
   localparam int DIFF_W   = 46;   // 2*dot - norms, signed Q.25
   localparam int TEMP_W   = 16;   // temperature, signed Q7.8
   localparam int SCORE_W  = 48;   // score, signed Q.24
   localparam int HALF_W   = 23;   // split point of the diff for the multiply
   localparam int PLO_W    = HALF_W + 1 + TEMP_W;        // 40
   localparam int PHI_W    = (DIFF_W - HALF_W) + TEMP_W; // 39
   localparam int FULL_W   = 62;   // full diff * temperature product
   localparam int RND_SH   = 9;    // Q.33 -> Q.24
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic signed [TEMP_W-1:0] TEMP_RESET = 16'sd256;

   // register word index, taken from paddr[2]
   localparam logic REG_TEMPERATURE = 1'b0;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   typedef struct packed {
      logic accept;     // load element products
      logic diff_load;  // capture diff, clear the row sums
      logic mul_load;   // capture partial products
      logic out_load;   // load the result register
   } cmd_type;

endpackage

// ===== src/rdsa_csr.sv =====
// ----------------------------------------------------------------------------
// rdsa_csr
// APB-style register file holding the temperature register.
// ----------------------------------------------------------------------------
module rdsa_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [rdsa_pkg::CSR_AW-1:0]            paddr,
   input  logic [rdsa_pkg::CSR_DW-1:0]            pwdata,
   output logic [rdsa_pkg::CSR_DW-1:0]            prdata,
   output logic                                   pready,
   output logic signed [rdsa_pkg::TEMP_W-1:0]     temperature
);

   logic signed [rdsa_pkg::TEMP_W-1:0] temperature_ff;
   logic signed [rdsa_pkg::TEMP_W-1:0] temperature_in;
   logic                               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == rdsa_pkg::REG_TEMPERATURE);

   always_comb begin
      temperature_in = temperature_ff;
      if (wr_en) begin
         temperature_in = pwdata[rdsa_pkg::TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temperature_ff <= rdsa_pkg::TEMP_RESET;
      end else begin
         temperature_ff <= temperature_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == rdsa_pkg::REG_TEMPERATURE) begin
         prdata = {{(rdsa_pkg::CSR_DW-rdsa_pkg::TEMP_W){temperature_ff[rdsa_pkg::TEMP_W-1]}},
                   temperature_ff};
      end
   end

   assign temperature = temperature_ff;

endmodule

// ===== src/rdsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdsa_ctrl
// Sequencer: streams elements, then walks the row score through the datapath.
// ----------------------------------------------------------------------------
module rdsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_element,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rdsa_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC,
      S_DIFF,
      S_MUL,
      S_SUM
   } state_type;

   state_type state_ff, state_in;
   logic      out_vld_ff, out_vld_in;
   logic      out_free;

   // result register is free if empty or drained this cycle
   assign out_free = !out_vld_ff || !rsp_stall;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      out_vld_in    = out_vld_ff;
      if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && req_last_element) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff_load = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               out_vld_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_vld_ff;

endmodule

// ===== src/rdsa_datapath.sv =====
// ----------------------------------------------------------------------------
// rdsa_datapath
// Element multipliers, saturating row sums, split score multiply, rounding.
// ----------------------------------------------------------------------------
module rdsa_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rdsa_pkg::cmd_type                      cmd,
   input  logic signed [rdsa_pkg::ELEM_W-1:0]     query_element,
   input  logic signed [rdsa_pkg::ELEM_W-1:0]     key_element,
   input  logic                                   last_row,
   input  logic signed [rdsa_pkg::TEMP_W-1:0]     temperature,
   output logic signed [rdsa_pkg::SCORE_W-1:0]    score,
   output logic                                   final_row,
   output logic                                   saturated
);

   localparam int PW = rdsa_pkg::PROD_W;
   localparam int NW = rdsa_pkg::NORM_W;
   localparam int DW = rdsa_pkg::DOT_W;
   localparam int FW = rdsa_pkg::FULL_W;
   localparam int SH = rdsa_pkg::RND_SH;
   localparam int SW = rdsa_pkg::SCORE_W;
   localparam int HW = rdsa_pkg::HALF_W;
   localparam int OVF_W = FW - SH - SW + 1;  // top bits that must all match

   // product stage
   logic signed [PW-1:0] qq_ff, kk_ff, qk_ff;
   logic                 prod_vld_ff;
   logic                 row_flag_ff;

   // row sums
   logic [NW-1:0]        qn_ff, qn_in;
   logic [NW-1:0]        kn_ff, kn_in;
   logic [DW-1:0]        dot_ff, dot_in;
   logic [NW:0]          qn_sum, kn_sum;
   logic [DW:0]          dot_sum;

   // score stages
   logic [rdsa_pkg::DIFF_W-1:0]            diff_ff, diff_in;
   logic signed [rdsa_pkg::PLO_W-1:0]      plo_ff;
   logic signed [rdsa_pkg::PHI_W-1:0]      phi_ff;
   logic signed [FW-1:0]                   full;
   logic                                   ovf;

   logic signed [SW-1:0] score_ff;
   logic                 final_row_ff;
   logic                 saturated_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         qq_ff       <= PW'(query_element) * PW'(query_element);
         kk_ff       <= PW'(key_element) * PW'(key_element);
         qk_ff       <= PW'(query_element) * PW'(key_element);
         row_flag_ff <= last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.accept;
      end
   end

   // saturating accumulate; squares are never negative
   assign qn_sum  = {1'b0, qn_ff} + {{(NW+1-PW){1'b0}}, qq_ff};
   assign kn_sum  = {1'b0, kn_ff} + {{(NW+1-PW){1'b0}}, kk_ff};
   assign dot_sum = {dot_ff[DW-1], dot_ff} + {{(DW+1-PW){qk_ff[PW-1]}}, qk_ff};

   always_comb begin
      qn_in  = qn_ff;
      kn_in  = kn_ff;
      dot_in = dot_ff;
      if (cmd.diff_load) begin
         qn_in  = '0;
         kn_in  = '0;
         dot_in = '0;
      end else if (prod_vld_ff) begin
         qn_in  = qn_sum[NW] ? {NW{1'b1}} : qn_sum[NW-1:0];
         kn_in  = kn_sum[NW] ? {NW{1'b1}} : kn_sum[NW-1:0];
         if (dot_sum[DW] != dot_sum[DW-1]) begin
            dot_in = {dot_sum[DW], {(DW-1){!dot_sum[DW]}}};
         end else begin
            dot_in = dot_sum[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qn_ff  <= '0;
         kn_ff  <= '0;
         dot_ff <= '0;
      end else begin
         qn_ff  <= qn_in;
         kn_ff  <= kn_in;
         dot_ff <= dot_in;
      end
   end

   // 2*dot - qn - kn, Q.25
   assign diff_in = {dot_ff[DW-1], dot_ff, 1'b0}
                  - {3'b000, qn_ff}
                  - {3'b000, kn_ff};

   always_ff @(posedge clock) begin
      if (cmd.diff_load) begin
         diff_ff <= diff_in;
      end
   end

   // diff = hi * 2^23 + lo, lo unsigned
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         plo_ff <= rdsa_pkg::PLO_W'($signed({1'b0, diff_ff[HW-1:0]}))
                 * rdsa_pkg::PLO_W'(temperature);
         phi_ff <= rdsa_pkg::PHI_W'($signed(diff_ff[rdsa_pkg::DIFF_W-1:HW]))
                 * rdsa_pkg::PHI_W'(temperature);
      end
   end

   // recombine, add half an lsb, floor shift by 9, clip to 48 bits
   assign full = (FW'(phi_ff) <<< HW) + FW'(plo_ff) + FW'(256);
   assign ovf  = (full[FW-1 -: OVF_W] != {OVF_W{full[FW-1]}});

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         final_row_ff <= row_flag_ff;
         saturated_ff <= ovf;
         if (ovf) begin
            score_ff <= full[FW-1] ? rdsa_pkg::SCORE_MIN : rdsa_pkg::SCORE_MAX;
         end else begin
            score_ff <= full[SH+SW-1:SH];
         end
      end
   end

   assign score     = score_ff;
   assign final_row = final_row_ff;
   assign saturated = saturated_ff;

endmodule

// ===== src/row_distance_score_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// row_distance_score_accumulator_core
// Scaled negative half squared distance between paired query and key rows.
// Throughput: one element beat per cycle inside a row; the sequencer stalls
//   the element side after each last-element beat while the score is formed.
// Score path: the last-element beat is followed by ACC, DIFF, MUL and SUM.
// Reset (synchronous): clears row sums, sequencer and result valid; sets
//   temperature to 1.0 (Q7.8 256).
// ----------------------------------------------------------------------------
module row_distance_score_accumulator_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // element beats
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [rdsa_pkg::ELEM_W-1:0]     req_query_element,
   input  logic signed [rdsa_pkg::ELEM_W-1:0]     req_key_element,
   input  logic                                   req_last_element,
   input  logic                                   req_last_row,
   // score beats
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [rdsa_pkg::SCORE_W-1:0]    rsp_score,
   output logic                                   rsp_final_row,
   output logic                                   rsp_saturated,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [rdsa_pkg::CSR_AW-1:0]            csr_paddr,
   input  logic [rdsa_pkg::CSR_DW-1:0]            csr_pwdata,
   output logic [rdsa_pkg::CSR_DW-1:0]            csr_prdata,
   output logic                                   csr_pready
);

   // Sequence per row:
   //   element beats: products registered, summed next cycle (saturating)
   //   last beat -> ACC (last sum) -> DIFF (2*dot - norms, sums clear)
   //   -> MUL (24x16 and 23x16 partial products) -> SUM (round, clip, result reg)
   // The result register parts the two sides, so a new row can stream in
   // while the previous score still waits for the sink.

   rdsa_pkg::cmd_type                  cmd;
   logic signed [rdsa_pkg::TEMP_W-1:0] temperature;

   rdsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .temperature (temperature)
   );

   rdsa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_last_element (req_last_element),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd)
   );

   rdsa_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .query_element (req_query_element),
      .key_element   (req_key_element),
      .last_row      (req_last_row),
      .temperature   (temperature),
      .score         (rsp_score),
      .final_row     (rsp_final_row),
      .saturated     (rsp_saturated)
   );

endmodule

// ===== src/rdsa_checker.sv =====
// ----------------------------------------------------------------------------
// rdsa_checker
// Port-level assertions for the row distance score block, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdsa_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_last_element,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [rdsa_pkg::SCORE_W-1:0]  rsp_score,
   input logic                                 rsp_saturated
);

   // closing a row always stalls the element side while the score is formed
   `ASSERT_CLK_RST(a_last_stalls, clock, reset, req_valid && !req_stall && req_last_element |=> req_stall, "no stall after last element")

   // a new score only shows up out of a scoring pass
   `ASSERT_CLK_RST(a_rsp_from_pass, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "score beat without scoring pass")

   // a clipped score sits at one of the range ends
   `ASSERT_CLK_RST(a_sat_clip, clock, reset, rsp_valid && rsp_saturated |-> (rsp_score == rdsa_pkg::SCORE_MAX) || (rsp_score == rdsa_pkg::SCORE_MIN), "saturated score not at limit")

   // stalled score beat holds
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_score), "stalled score beat changed")

endmodule

bind row_distance_score_accumulator_core rdsa_checker u_rdsa_checker (.*);

// ===== tb/row_distance_score_accumulator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_distance_score_accumulator_core_tb
// Streams query/key element beats through the row distance score block and
// checks every score beat against a cycle-free model of the row sums or a
// fixed table score. A short table of directed rows comes first, then random
// rows in phases with different temperatures. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module row_distance_score_accumulator_core_tb;

   typedef logic signed [rdsa_pkg::ELEM_W-1:0]  elem_type;
   typedef logic signed [rdsa_pkg::TEMP_W-1:0]  scale_type;
   typedef logic signed [rdsa_pkg::SCORE_W-1:0] score_type;

   // one expected score beat
   typedef struct packed {
      score_type score;
      bit        final_row;
      bit        sat;
   } score_beat_type;

   // directed row: the element pair is repeated reps times, and only the
   // last repeat carries last_element; fixed rows carry their score here
   typedef struct packed {
      scale_type   scale;
      elem_type    q;
      elem_type    k;
      bit          last_el;
      bit          last_rw;
      int unsigned reps;
      bit          fixed;
      score_type   score;
      bit          sat;
   } plan_row_type;

   localparam int NUM_PLAN      = 17;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 36;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [rdsa_pkg::CSR_AW-1:0] SCALE_ADDR = {rdsa_pkg::REG_TEMPERATURE, 2'b00};

   localparam longint NORM_TOP   = (64'sd1 <<< rdsa_pkg::NORM_W) - 1;
   localparam longint DOT_TOP    = (64'sd1 <<< (rdsa_pkg::DOT_W - 1)) - 1;
   localparam longint DOT_BOTTOM = -(64'sd1 <<< (rdsa_pkg::DOT_W - 1));
   localparam longint SCORE_TOP    = rdsa_pkg::SCORE_MAX;
   localparam longint SCORE_BOTTOM = rdsa_pkg::SCORE_MIN;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   elem_type                      req_query_element;
   elem_type                      req_key_element;
   logic                          req_last_element;
   logic                          req_last_row;
   logic                          rsp_valid;
   logic                          rsp_stall;
   score_type                     rsp_score;
   logic                          rsp_final_row;
   logic                          rsp_saturated;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [rdsa_pkg::CSR_AW-1:0]   csr_paddr;
   logic [rdsa_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [rdsa_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   // model state: running row sums and the temperature
   longint         run_dot;
   longint         run_qnorm;
   longint         run_knorm;
   scale_type      scale;

   score_beat_type pending_scores[$];
   score_beat_type due;
   plan_row_type   plan[NUM_PLAN];
   int             err_count;
   bit             idle_on;      // random idling on both sides
   int             rsp_hold_left;

   row_distance_score_accumulator_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_query_element (req_query_element),
      .req_key_element   (req_key_element),
      .req_last_element  (req_last_element),
      .req_last_row      (req_last_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_score         (rsp_score),
      .rsp_final_row     (rsp_final_row),
      .rsp_saturated     (rsp_saturated),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Folds one element pair into the row sums. On the closing element the
   // score is formed: diff = 2*dot - qnorm - knorm is Q.25, times the Q7.8
   // temperature gives Q.33, and +256 then an arithmetic shift by 9 rounds
   // half up into Q.24 before the 48-bit clip. Sums clear after a score.
   function automatic bit fold_element(input elem_type q, input elem_type k, input bit last_el,
                                       input bit last_rw, output score_beat_type beat);
      longint qv;
      longint kv;
      longint diff;
      longint prod;
      longint sc;
      qv = q;
      kv = k;
      beat = '0;
      run_qnorm = clip(run_qnorm + qv * qv, 0, NORM_TOP);
      run_knorm = clip(run_knorm + kv * kv, 0, NORM_TOP);
      run_dot   = clip(run_dot + qv * kv, DOT_BOTTOM, DOT_TOP);
      if (!last_el)
         return 1'b0;
      diff = 2 * run_dot - run_qnorm - run_knorm;
      prod = diff * longint'(scale);
      sc   = (prod + 256) >>> rdsa_pkg::RND_SH;
      beat.sat       = (sc > SCORE_TOP) || (sc < SCORE_BOTTOM);
      sc             = clip(sc, SCORE_BOTTOM, SCORE_TOP);
      beat.score     = sc[rdsa_pkg::SCORE_W-1:0];
      beat.final_row = last_rw;
      run_dot   = 0;
      run_qnorm = 0;
      run_knorm = 0;
      return 1'b1;
   endfunction

   function automatic elem_type pick_element();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: return elem_type'(int'($urandom_range(0, 64)) - 32);
         default: return elem_type'($urandom);
      endcase
   endfunction

   // One element beat. An optional idle burst first, then valid stays up
   // until the beat is taken. A fixed beat replaces the model's score.
   task automatic send_beat(input elem_type q, input elem_type k, input bit last_el,
                            input bit last_rw, input bit fixed, input score_beat_type given);
      int             gap;
      score_beat_type beat;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_query_element <= q;
      req_key_element   <= k;
      req_last_element  <= last_el;
      req_last_row      <= last_rw;
      do @(posedge clock); while (req_stall);
      if (fold_element(q, k, last_el, last_rw, beat))
         pending_scores.push_back(fixed ? given : beat);
   endtask

   // Block goes idle: no beat offered, every score in, then the pipe empties.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_scores.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Temperature write, then a read back of the same register.
   task automatic write_scale(input scale_type value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SCALE_ADDR;
      csr_pwdata  <= {{(rdsa_pkg::CSR_DW-rdsa_pkg::TEMP_W){value[rdsa_pkg::TEMP_W-1]}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      scale = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[rdsa_pkg::TEMP_W-1:0] !== value) begin
         $error("temperature: expected %0d, got %0d", value,
                $signed(csr_prdata[rdsa_pkg::TEMP_W-1:0]));
         err_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Result side stall: random bursts while idling is on.
   always @(negedge clock) begin
      if (rsp_hold_left == 0 && idle_on && $urandom_range(0, 5) == 0)
         rsp_hold_left = $urandom_range(1, 8);
      rsp_stall <= (rsp_hold_left > 0);
      if (rsp_hold_left > 0)
         rsp_hold_left--;
   end

   // Score beat checker: each taken beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scores.size() == 0) begin
            $error("score beat %0d with nothing expected", rsp_score);
            err_count++;
         end else begin
            due = pending_scores.pop_front();
            if (rsp_score !== due.score) begin
               $error("score: expected %0d, got %0d", due.score, rsp_score);
               err_count++;
            end
            if (rsp_final_row !== due.final_row) begin
               $error("final_row: expected %0b, got %0b", due.final_row, rsp_final_row);
               err_count++;
            end
            if (rsp_saturated !== due.sat) begin
               $error("saturated: expected %0b, got %0b", due.sat, rsp_saturated);
               err_count++;
            end
         end
      end
   end

   initial begin
      int             phase_items;
      int             row_len;
      int             n;
      elem_type       q;
      elem_type       k;
      scale_type      next_scale;
      score_beat_type given;

      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_query_element = '0;
      req_key_element   = '0;
      req_last_element  = 1'b0;
      req_last_row      = 1'b0;
      rsp_stall         = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      run_dot           = 0;
      run_qnorm         = 0;
      run_knorm         = 0;
      scale             = rdsa_pkg::TEMP_RESET;
      err_count         = 0;
      idle_on           = 1'b1;
      rsp_hold_left     = 0;

      // Directed rows. Columns: temperature, query, key, last_element,
      // last_row, repeats, fixed score?, score, saturated.
      // After reset at 1.0: a lone zero pair, then 1.0 against 0 gives -0.5.
      plan[0]  = '{16'sd256, 16'sd0, 16'sd0, 1'b1, 1'b0, 1, 1'b1, 48'sd0, 1'b0};
      plan[1]  = '{16'sd256, 16'sd4096, 16'sd0, 1'b1, 1'b1, 1, 1'b1, -48'sd8388608, 1'b0};
      // four element row with opposite extremes; last_row on an inner beat
      plan[2]  = '{16'sd256, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 1, 1'b0, 48'sd0, 1'b0};
      plan[3]  = '{16'sd256, 16'sh8000, 16'sh7FFF, 1'b0, 1'b1, 1, 1'b0, 48'sd0, 1'b0};
      plan[4]  = '{16'sd256, -16'sd1, 16'sd1, 1'b0, 1'b0, 1, 1'b0, 48'sd0, 1'b0};
      plan[5]  = '{16'sd256, 16'sh5555, 16'shAAAA, 1'b1, 1'b0, 1, 1'b0, 48'sd0, 1'b0};
      plan[6]  = '{16'sd256, 16'sh8000, 16'sh8000, 1'b1, 1'b1, 1, 1'b0, 48'sd0, 1'b0};
      // zero temperature always scores zero; negative one flips the sign
      plan[7]  = '{16'sd0, 16'sd12345, -16'sd321, 1'b1, 1'b0, 1, 1'b1, 48'sd0, 1'b0};
      plan[8]  = '{-16'sd256, 16'sd4096, 16'sd0, 1'b1, 1'b0, 1, 1'b1, 48'sd8388608, 1'b0};
      // rounding: two exact half LSB cases, then extreme rows at a +-1 LSB temperature
      plan[9]  = '{-16'sd256, 16'sd1, 16'sd0, 1'b1, 1'b1, 1, 1'b0, 48'sd0, 1'b0};
      plan[10] = '{16'sd256, 16'sd1, 16'sd0, 1'b1, 1'b0, 1, 1'b0, 48'sd0, 1'b0};
      plan[11] = '{16'sd1, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 1, 1'b0, 48'sd0, 1'b0};
      plan[12] = '{-16'sd1, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1, 1'b0, 48'sd0, 1'b0};
      // score clipped low, then high
      plan[13] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 520, 1'b1,
                   rdsa_pkg::SCORE_MIN, 1'b1};
      plan[14] = '{16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 520, 1'b1,
                   rdsa_pkg::SCORE_MAX, 1'b1};
      // equal elements: difference cancels to zero
      plan[15] = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 3, 1'b1, 48'sd0, 1'b0};
      // equal pair at 1.0: sums must have cleared
      plan[16] = '{16'sd256, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 1, 1'b1, 48'sd0, 1'b0};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; temperature changes only land on row boundaries
      foreach (plan[i]) begin
         if (plan[i].scale != scale) begin
            settle();
            write_scale(plan[i].scale);
         end
         given = '{plan[i].score, plan[i].last_rw, plan[i].sat};
         for (int r = 0; r < plan[i].reps; r++) begin
            n = (r == plan[i].reps - 1);
            send_beat(plan[i].q, plan[i].k, n ? plan[i].last_el : 1'b0, plan[i].last_rw,
                      n ? plan[i].fixed : 1'b0, given);
         end
      end

      // Random phases, each under its own temperature. Phase three runs with
      // no idling; the last phase is the quiet tail of the run.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: next_scale = 16'sh7FFF;
            1: next_scale = 16'sh8000;
            2: next_scale = '0;
            3: next_scale = 16'sd1;
            4: next_scale = -16'sd1;
            7: next_scale = rdsa_pkg::TEMP_RESET;
            default: next_scale = scale_type'($urandom);
         endcase
         settle();
         idle_on = (phase != 3) && (phase != NUM_PHASES - 1);
         write_scale(next_scale);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
               row_len = 1;
            else
               row_len = $urandom_range(2, 12);
            for (int r = 0; r < row_len; r++) begin
               q = pick_element();
               k = pick_element();
               send_beat(q, k, r == row_len - 1, 1'($urandom_range(0, 1)), 1'b0, '0);
               phase_items++;
            end
         end
      end

      settle();
      if (err_count == 0 && pending_scores.size() == 0)
         $display("row_distance_score_accumulator_core_tb: done, clean");
      else
         $display("row_distance_score_accumulator_core_tb: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("row_distance_score_accumulator_core_tb: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/rdsa_pkg.sv
src/rdsa_csr.sv
src/rdsa_ctrl.sv
src/rdsa_datapath.sv
src/row_distance_score_accumulator_core.sv
src/rdsa_checker.sv
tb/row_distance_score_accumulator_core_tb.sv
